FILE: hw/rtl/crf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crf_pkg
// shared types and constants of the can fragment reassembler
// ----------------------------------------------------------------------------
package crf_pkg;

	localparam int MSG_SLOTS = 8;
	localparam int ID_W      = 11;
	localparam int PART_W    = 48;
	localparam int CNT_W     = 32;
	localparam int GROUPS    = 4;
	localparam int REM_PARTS = 3;

	localparam logic [3:0] DLC_FULL = 4'd8;

	localparam logic [2:0] MSG_GIMBAL_PRI = 3'd3;
	localparam logic [2:0] MSG_GIMBAL_AUX = 3'd4;
	localparam logic [2:0] MSG_CHASSIS    = 3'd5;
	localparam logic [2:0] MSG_SHOOTER    = 3'd6;
	localparam logic [1:0] REM_FLAG_PART  = 2'd2;

	localparam logic [7:0] REM_FLAG_MASK = 8'hBF;
	localparam int         REM_ONLINE_BIT = 7;

	localparam logic CFG_BASE_ID = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	typedef enum logic {
		OP_FRAME = 1'b0,
		OP_TICK  = 1'b1
	} opcode_t;

	typedef enum logic {
		ST_OK     = 1'b0,
		ST_REJECT = 1'b1
	} status_t;

	typedef enum logic [2:0] {
		GRP_NONE    = 3'd0,
		GRP_REMOTE  = 3'd1,
		GRP_GIMBAL  = 3'd2,
		GRP_CHASSIS = 3'd3,
		GRP_SHOOTER = 3'd4
	} group_t;

	typedef struct packed {
		logic              opcode;
		logic              is_standard_id;
		logic              is_data_frame;
		logic [3:0]        byte_count;
		logic [ID_W-1:0]   can_id;
		logic [7:0]        seq_byte;
		logic [7:0]        flag_byte;
		logic [PART_W-1:0] payload_word;
		logic [CNT_W-1:0]  tick_ms;
	} in_beat_t;

	typedef struct packed {
		status_t                          status;
		group_t                           group;
		logic [1:0]                       last_idx;
		logic [1:0]                       flag_idx;
		logic [7:0]                       flags;
		logic [REM_PARTS-1:0][PART_W-1:0] payload;
		logic [CNT_W-1:0]                 commit_count;
		logic [GROUPS-1:0]                online_mask;
	} res_bundle_t;

endpackage
`default_nettype wire

FILE: hw/rtl/crf_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crf_core
// frame filter, fragment staging, elapsed counters and result assembly
// ----------------------------------------------------------------------------
module crf_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire crf_pkg::in_beat_t   beat,
	input  wire logic [10:0]         base_id,
	input  wire logic [31:0]         offline_timeout,
	output crf_pkg::res_bundle_t     res
);
	import crf_pkg::*;

	logic [REM_PARTS-1:0][PART_W-1:0] rem_parts_q, rem_parts_n;
	logic [7:0]                       rem_flag_q, rem_flag_n;
	logic [7:0]                       rem_seq_q;
	logic [REM_PARTS-1:0]             rem_got_q, rem_got_n;
	logic [1:0][PART_W-1:0]           gim_parts_q, gim_parts_n;
	logic [1:0]                       gim_flag_q, gim_flag_n;
	logic [7:0]                       gim_seq_q;
	logic [1:0]                       gim_got_q, gim_got_n;
	logic [GROUPS-1:0][CNT_W-1:0]     elapsed_q, elapsed_n;
	logic [GROUPS-1:0]                online_q, online_n;
	logic [CNT_W-1:0]                 commits_q, commits_n;

	logic [ID_W:0]  win_hi;
	logic           frame_ok;
	logic [2:0]     msg;
	logic           is_frame, is_tick;
	logic           is_remote, is_gimbal, is_chassis, is_shooter;
	logic           rem_restart, gim_restart;
	logic           gim_idx;
	logic           commit_r, commit_g;
	logic [CNT_W:0] sum;

	always_comb begin
		win_hi   = {1'b0, base_id} + (ID_W + 1)'(MSG_SLOTS);
		frame_ok = beat.is_standard_id && beat.is_data_frame &&
			(beat.byte_count == DLC_FULL) && (beat.can_id >= base_id) &&
			({1'b0, beat.can_id} < win_hi);
		msg      = 3'(beat.can_id - base_id);
		is_tick  = (beat.opcode == OP_TICK);
		is_frame = (beat.opcode == OP_FRAME);

		is_remote  = is_frame && frame_ok && (msg < MSG_GIMBAL_PRI);
		is_gimbal  = is_frame && frame_ok &&
			((msg == MSG_GIMBAL_PRI) || (msg == MSG_GIMBAL_AUX));
		is_chassis = is_frame && frame_ok && (msg == MSG_CHASSIS);
		is_shooter = is_frame && frame_ok && (msg == MSG_SHOOTER);

		// remote staging
		rem_restart = (rem_got_q == '0) || (rem_seq_q != beat.seq_byte);
		rem_parts_n = rem_restart ? '0 : rem_parts_q;
		rem_flag_n  = rem_restart ? '0 : rem_flag_q;
		rem_got_n   = rem_restart ? '0 : rem_got_q;
		rem_parts_n[msg[1:0]] = beat.payload_word;
		if (msg[1:0] == REM_FLAG_PART) begin
			rem_flag_n = beat.flag_byte & REM_FLAG_MASK;
		end
		rem_got_n = rem_got_n | (REM_PARTS'(1) << msg[1:0]);
		commit_r  = is_remote && (rem_got_n == '1);

		// gimbal staging
		gim_idx     = msg[2];
		gim_restart = (gim_got_q == '0) || (gim_seq_q != beat.seq_byte);
		gim_parts_n = gim_restart ? '0 : gim_parts_q;
		gim_flag_n  = gim_restart ? '0 : gim_flag_q;
		gim_got_n   = gim_restart ? '0 : gim_got_q;
		gim_parts_n[gim_idx] = beat.payload_word;
		if (msg == MSG_GIMBAL_PRI) begin
			gim_flag_n = beat.flag_byte[1:0];
		end
		gim_got_n = gim_got_n | (2'(1) << gim_idx);
		commit_g  = is_gimbal && (gim_got_n == '1);

		// elapsed counters and online bits
		elapsed_n = elapsed_q;
		online_n  = online_q;
		sum       = '0;
		if (is_tick) begin
			for (int i = 0; i < GROUPS; i++) begin
				sum = {1'b0, elapsed_q[i]} + {1'b0, beat.tick_ms};
				elapsed_n[i] = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
				if ((offline_timeout != '0) && (elapsed_n[i] > offline_timeout)) begin
					online_n[i] = 1'b0;
				end
			end
		end
		if (commit_r) begin
			elapsed_n[0] = '0;
			online_n[0]  = rem_flag_n[REM_ONLINE_BIT];
		end
		if (commit_g) begin
			elapsed_n[1] = '0;
			online_n[1]  = 1'b1;
		end
		if (is_chassis) begin
			elapsed_n[2] = '0;
			online_n[2]  = 1'b1;
		end
		if (is_shooter) begin
			elapsed_n[3] = '0;
			online_n[3]  = 1'b1;
		end

		commits_n = commits_q;
		if (commit_r && (commits_q != '1)) begin
			commits_n = commits_q + 1'b1;
		end

		// result bundle
		res              = '0;
		res.status       = ST_OK;
		res.group        = GRP_NONE;
		res.commit_count = commits_n;
		res.online_mask  = online_n;
		if (is_frame && !frame_ok) begin
			res.status = ST_REJECT;
		end else if (is_chassis) begin
			res.group      = GRP_CHASSIS;
			res.payload[0] = beat.payload_word;
			res.flags      = {6'b0, beat.flag_byte[1:0]};
		end else if (is_shooter) begin
			res.group      = GRP_SHOOTER;
			res.payload[0] = beat.payload_word;
		end else if (commit_r) begin
			res.group    = GRP_REMOTE;
			res.last_idx = 2'(REM_PARTS - 1);
			res.flag_idx = REM_FLAG_PART;
			res.flags    = rem_flag_n;
			res.payload  = rem_parts_n;
		end else if (commit_g) begin
			res.group      = GRP_GIMBAL;
			res.last_idx   = 2'd1;
			res.flags      = {6'b0, gim_flag_n};
			res.payload[0] = gim_parts_n[0];
			res.payload[1] = gim_parts_n[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_got_q <= '0;
			gim_got_q <= '0;
			elapsed_q <= '0;
			online_q  <= '0;
			commits_q <= '0;
		end else if (take) begin
			if (is_remote) begin
				rem_got_q <= commit_r ? '0 : rem_got_n;
			end
			if (is_gimbal) begin
				gim_got_q <= commit_g ? '0 : gim_got_n;
			end
			elapsed_q <= elapsed_n;
			online_q  <= online_n;
			commits_q <= commits_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_remote) begin
			rem_parts_q <= rem_parts_n;
			rem_flag_q  <= rem_flag_n;
			rem_seq_q   <= beat.seq_byte;
		end
		if (take && is_gimbal) begin
			gim_parts_q <= gim_parts_n;
			gim_flag_q  <= gim_flag_n;
			gim_seq_q   <= beat.seq_byte;
		end
	end

	a_commits_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (commits_q >= $past(commits_q)))
		else $error("remote commit count went down");

	a_remote_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		rem_got_q != '1)
		else $error("complete remote group left staged");

	a_gimbal_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		gim_got_q != '1)
		else $error("complete gimbal group left staged");

endmodule
`default_nettype wire

FILE: hw/rtl/crf_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crf_out_buf
// result register holding one input's results and sending them beat by beat
// ----------------------------------------------------------------------------
module crf_out_buf (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load_req,
	output logic                      take,
	input  wire crf_pkg::res_bundle_t res,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [0:0]                status,
	output logic [2:0]                group,
	output logic [1:0]                part_index,
	output logic [47:0]               part_payload,
	output logic [7:0]                part_flags,
	output logic [31:0]               commit_count,
	output logic [3:0]                online_mask,
	output logic                      last
);
	import crf_pkg::*;

	res_bundle_t bundle_q;
	logic        valid_q;
	logic [1:0]  idx_q;
	logic        is_last;
	logic        can_load;

	always_comb begin
		is_last      = (idx_q == bundle_q.last_idx);
		can_load     = !valid_q || (out_ready && is_last);
		take         = load_req && can_load;
		out_valid    = valid_q;
		status       = bundle_q.status;
		group        = bundle_q.group;
		part_index   = idx_q;
		part_payload = bundle_q.payload[idx_q];
		part_flags   = (idx_q == bundle_q.flag_idx) ? bundle_q.flags : '0;
		commit_count = bundle_q.commit_count;
		online_mask  = bundle_q.online_mask;
		last         = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (take) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && out_ready) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bundle_q <= res;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (idx_q <= bundle_q.last_idx))
		else $error("part index past last part");

	a_more_parts: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_ready && !is_last) |=> (valid_q && (idx_q == $past(idx_q) + 2'd1)))
		else $error("multi-part result dropped a beat");

	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (bundle_q.status == ST_REJECT)) |->
		((bundle_q.last_idx == 2'd0) && (bundle_q.group == GRP_NONE)))
		else $error("rejected frame with group results");

endmodule
`default_nettype wire

FILE: hw/rtl/can_fragment_reassembler_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// can_fragment_reassembler_top
// receive-side reassembly of fragmented board link messages carried on can
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): one beat is a received frame or a time
//   tick. frames outside the message window or not standard 8-byte data frames
//   give a single reject result. completed remote groups give three result
//   beats, gimbal groups two, every other input exactly one; the final beat
//   of an input carries last.
//   output channel (out_valid/out_ready): one result beat per accepted handshake.
//   configuration: cfg_wen writes cfg_wdata to register cfg_index
//   (0 base id, 1 offline timeout) in the same edge; write only while idle.
//   path: an accepted beat passes the input register, then the result register.
//   throughput: one input per cycle while each gives one result and out_ready is
//   high; a remote commit holds the result register until its three beats go, a
//   gimbal commit until its two. the input register holds one beat meanwhile.
//   reset: control bits, counters, online bits and config clear, data not; no pass.
//   stall: when out_ready is low the result register holds, then the input
//   register fills and in_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module can_fragment_reassembler_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        opcode,
	input  wire logic        is_standard_id,
	input  wire logic        is_data_frame,
	input  wire logic [3:0]  byte_count,
	input  wire logic [10:0] can_id,
	input  wire logic [7:0]  seq_byte,
	input  wire logic [7:0]  flag_byte,
	input  wire logic [47:0] payload_word,
	input  wire logic [31:0] tick_ms,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [0:0]       status,
	output logic [2:0]       group,
	output logic [1:0]       part_index,
	output logic [47:0]      part_payload,
	output logic [7:0]       part_flags,
	output logic [31:0]      commit_count,
	output logic [3:0]       online_mask,
	output logic             last
);
	import crf_pkg::*;

	logic [ID_W-1:0]  base_id_q;
	logic [CNT_W-1:0] timeout_q;
	in_beat_t         in_beat;
	in_beat_t         beat_s1;
	logic             valid_s1;
	logic             take;
	res_bundle_t      res;

	always_comb begin
		in_beat.opcode         = opcode;
		in_beat.is_standard_id = is_standard_id;
		in_beat.is_data_frame  = is_data_frame;
		in_beat.byte_count     = byte_count;
		in_beat.can_id         = can_id;
		in_beat.seq_byte       = seq_byte;
		in_beat.flag_byte      = flag_byte;
		in_beat.payload_word   = payload_word;
		in_beat.tick_ms        = tick_ms;
		in_ready               = !valid_s1 || take;
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_id_q <= '0;
			timeout_q <= '0;
		end else if (cfg_wen) begin
			if (cfg_index == CFG_BASE_ID) begin
				base_id_q <= cfg_wdata[ID_W-1:0];
			end else if (cfg_index == CFG_TIMEOUT) begin
				timeout_q <= cfg_wdata;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= in_beat;
		end
	end

	crf_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.beat            (beat_s1),
		.base_id         (base_id_q),
		.offline_timeout (timeout_q),
		.res             (res)
	);

	crf_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_req     (valid_s1),
		.take         (take),
		.res          (res),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.group        (group),
		.part_index   (part_index),
		.part_payload (part_payload),
		.part_flags   (part_flags),
		.commit_count (commit_count),
		.online_mask  (online_mask),
		.last         (last)
	);

endmodule
`default_nettype wire
